>>> rtl/lcf_pkg.sv
// Shared constants and payload types for the LED colour cross-fade block.
package lcf_pkg;

  // Strip size and fade length
  localparam int unsigned PIXEL_COUNT = 16;
  localparam int unsigned FADE_STEPS  = 21;

  // Frame period after reset, in microseconds (about 60 Hz)
  localparam logic [31:0] PERIOD_RESET = 32'd16666;

  // Fade step counter: 0 .. FADE_STEPS-1 blend, FADE_STEPS exact target, then idle
  localparam int unsigned STEP_W = $clog2(FADE_STEPS + 2);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FADE_STEPS);
  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(FADE_STEPS + 1);

  // Remainder of a division by FADE_STEPS
  localparam int unsigned REM_W = $clog2(FADE_STEPS + 1);

  // Reciprocal of FADE_STEPS for the constant division
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP = (2 ** RECIP_SHIFT + FADE_STEPS - 1) / FADE_STEPS;

  // Pixel counter
  localparam int unsigned PIX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXEL_COUNT - 1);

  // Frame queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Request kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_COLOR = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] timestamp_us;
    logic [23:0] new_color;
  } lcf_in_t;

  typedef struct packed {
    logic [3:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } lcf_out_t;

  // One frame to be painted: the colour for every pixel
  typedef struct packed {
    logic        valid;
    logic [23:0] color;
  } lcf_frame_t;

endpackage

>>> rtl/led_color_crossfade_top.sv
// Top level of the LED colour cross-fade block: front end, frame queue and pixel sequencer.
// One request is taken every clock cycle while the two-entry frame queue has room: a
// colour request arms a fade, a tick that finds a frame due works out the frame colour in
// the same cycle and queues it. The pixel sequencer then emits one result per cycle while
// the output is taken, for each of the 16 pixels, and takes the next frame from the queue
// once the last pixel is loaded; the input stalls only while two frames wait there.
// Results stay in the output register until taken, independent of the input side.
module led_color_crossfade_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcf_pkg::lcf_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output lcf_pkg::lcf_out_t out_item,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  lcf_pkg::lcf_frame_t push;
  lcf_pkg::lcf_frame_t head;
  logic                q_full;
  logic                pop;

  lcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push)
  );

  lcf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  lcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Frames only come from accepted ticks and never land in a full queue
  a_push_tick : assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (in_valid && in_ready && in_item.kind == lcf_pkg::KIND_TICK && !q_full))
    else $error("frame queued without an accepted tick or into a full queue");

  // The sequencer only takes a frame that is there
  a_pop_head : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("frame taken from an empty queue");

  // The last pixel flag marks the final pixel index
  a_last_pixel : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_pixel) |-> (out_item.pixel_index == 4'(lcf_pkg::PIXEL_COUNT - 1)))
    else $error("last pixel flag on the wrong pixel");

endmodule

>>> rtl/lcf_front.sv
// Front end: takes requests, decides frame timing and steps the fade per channel.
module lcf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcf_pkg::lcf_in_t    in_item,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                q_full,
  output lcf_pkg::lcf_frame_t push
);

  typedef struct packed {
    logic signed [8:0]              q;
    logic [lcf_pkg::REM_W-1:0]      r;
  } lcf_acc_t;

  // Floor division of a channel difference by the fade length
  function automatic lcf_acc_t divmod_steps(input logic signed [8:0] d);
    logic [7:0]  mag;
    logic [24:0] prod;
    logic [7:0]  qm;
    logic [7:0]  rm;
    lcf_acc_t    res;
    mag  = d[8] ? 8'(-d) : d[7:0];
    prod = 25'(mag) * 25'(lcf_pkg::RECIP);
    qm   = 8'(prod >> lcf_pkg::RECIP_SHIFT);
    rm   = mag - 8'(16'(qm) * 16'(lcf_pkg::FADE_STEPS));
    if (!d[8]) begin
      res.q = $signed({1'b0, qm});
      res.r = lcf_pkg::REM_W'(rm);
    end else if (rm == 8'd0) begin
      res.q = -$signed({1'b0, qm});
      res.r = '0;
    end else begin
      res.q = -$signed({1'b0, qm}) - 9'sd1;
      res.r = lcf_pkg::REM_W'(8'(lcf_pkg::FADE_STEPS) - rm);
    end
    return res;
  endfunction

  // Move quotient and remainder on by one step of the difference
  function automatic lcf_acc_t advance_step(input lcf_acc_t acc, input lcf_acc_t inc);
    logic [lcf_pkg::REM_W:0] rsum;
    logic signed [9:0]       qsum;
    lcf_acc_t                res;
    rsum = {1'b0, acc.r} + {1'b0, inc.r};
    qsum = 10'(acc.q) + 10'(inc.q);
    if (rsum >= (lcf_pkg::REM_W + 1)'(lcf_pkg::FADE_STEPS)) begin
      rsum = rsum - (lcf_pkg::REM_W + 1)'(lcf_pkg::FADE_STEPS);
      qsum = qsum + 10'sd1;
    end
    res.q = qsum[8:0];
    res.r = rsum[lcf_pkg::REM_W-1:0];
    return res;
  endfunction

  logic [31:0]                period_r,  period_nxt;
  logic [31:0]                last_r,    last_nxt;
  logic                       pending_r, pending_nxt;
  logic [lcf_pkg::STEP_W-1:0] step_r,    step_nxt;
  logic [23:0]                target_r,  target_nxt;
  logic [23:0]                shown_r,   shown_nxt;
  logic [7:0]                 start_r [3];
  logic [7:0]                 start_nxt [3];
  lcf_acc_t                   acc_r [3];
  lcf_acc_t                   acc_nxt [3];
  lcf_acc_t                   inc_r [3];
  lcf_acc_t                   inc_nxt [3];

  logic                       accept;
  logic                       tick_acc;
  logic                       color_acc;
  logic [31:0]                diff;
  logic                       due;
  logic                       latch;
  logic [lcf_pkg::STEP_W-1:0] eff_step;
  logic                       step_run;
  logic                       step_end;
  logic                       emit;
  logic [23:0]                frame_color;
  logic signed [8:0]          diff_ch [3];
  lcf_acc_t                   div_ch [3];
  lcf_acc_t                   adv_ch [3];
  logic [7:0]                 blend_ch [3];

  // Classify the request and decide whether a frame is due
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign tick_acc  = accept && (in_item.kind == lcf_pkg::KIND_TICK);
  assign color_acc = accept && (in_item.kind == lcf_pkg::KIND_COLOR);
  assign diff      = in_item.timestamp_us - last_r;
  assign due       = tick_acc && (diff != 32'd0) && (diff >= period_r);
  assign latch     = due && pending_r;
  assign eff_step  = latch ? '0 : step_r;
  assign step_run  = eff_step < lcf_pkg::STEP_LAST;
  assign step_end  = eff_step == lcf_pkg::STEP_LAST;
  assign emit      = due && (step_run || step_end);

  // Per channel blend, fade set-up and step advance
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff_ch[c]  = $signed({1'b0, target_r[8*c +: 8]}) - $signed({1'b0, shown_r[8*c +: 8]});
      div_ch[c]   = divmod_steps(diff_ch[c]);
      adv_ch[c]   = advance_step(acc_r[c], inc_r[c]);
      blend_ch[c] = 8'($signed({2'b00, start_r[c]}) + $signed({acc_r[c].q[8], acc_r[c].q}));
      if (step_end) begin
        frame_color[8*c +: 8] = target_r[8*c +: 8];
      end else if (latch) begin
        frame_color[8*c +: 8] = shown_r[8*c +: 8];
      end else begin
        frame_color[8*c +: 8] = blend_ch[c];
      end
      start_nxt[c] = start_r[c];
      acc_nxt[c]   = acc_r[c];
      inc_nxt[c]   = inc_r[c];
      if (latch) begin
        start_nxt[c] = shown_r[8*c +: 8];
        acc_nxt[c]   = div_ch[c];
        inc_nxt[c]   = div_ch[c];
      end else if (due && step_run) begin
        acc_nxt[c] = adv_ch[c];
      end
    end
  end

  // Update timing, fade control and the shown colour
  always_comb begin
    period_nxt  = cfg_we ? cfg_wdata : period_r;
    last_nxt    = due ? in_item.timestamp_us : last_r;
    target_nxt  = color_acc ? in_item.new_color : target_r;
    shown_nxt   = emit ? frame_color : shown_r;
    pending_nxt = pending_r;
    if (color_acc) begin
      pending_nxt = 1'b1;
    end else if (latch) begin
      pending_nxt = 1'b0;
    end
    step_nxt = step_r;
    if (due) begin
      if (step_run) begin
        step_nxt = eff_step + 1'b1;
      end else if (step_end) begin
        step_nxt = lcf_pkg::STEP_IDLE;
      end
    end
  end

  // Hand each frame to the queue
  assign push.valid = emit;
  assign push.color = frame_color;

  // Control and colour state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= lcf_pkg::PERIOD_RESET;
      last_r    <= '0;
      pending_r <= 1'b0;
      step_r    <= lcf_pkg::STEP_IDLE;
      target_r  <= '0;
      shown_r   <= '0;
    end else begin
      period_r  <= period_nxt;
      last_r    <= last_nxt;
      pending_r <= pending_nxt;
      step_r    <= step_nxt;
      target_r  <= target_nxt;
      shown_r   <= shown_nxt;
    end
  end

  // Fade arithmetic, only read once a fade has been set up
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      start_r[c] <= start_nxt[c];
      acc_r[c]   <= acc_nxt[c];
      inc_r[c]   <= inc_nxt[c];
    end
  end

endmodule

>>> rtl/lcf_queue.sv
// Short frame queue between the front end and the pixel sequencer.
module lcf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  lcf_pkg::lcf_frame_t push,
  output logic                full,
  input  logic                pop,
  output lcf_pkg::lcf_frame_t head
);

  logic [23:0]                entry_r [lcf_pkg::QUEUE_DEPTH];
  logic [lcf_pkg::QPTR_W-1:0] wr_r, wr_nxt;
  logic [lcf_pkg::QPTR_W-1:0] rd_r, rd_nxt;
  logic [lcf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [lcf_pkg::QPTR_W-1:0] ptr_inc(input logic [lcf_pkg::QPTR_W-1:0] p);
    return (p == lcf_pkg::QPTR_W'(lcf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = cnt_r == lcf_pkg::QCNT_W'(lcf_pkg::QUEUE_DEPTH);
  assign head.valid = cnt_r != '0;
  assign head.color = entry_r[rd_r];

  // Advance pointers and fill count
  always_comb begin
    wr_nxt  = push.valid ? ptr_inc(wr_r) : wr_r;
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push.valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the frame colour
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_r] <= push.color;
    end
  end

endmodule

>>> rtl/lcf_back.sv
// Back end: paints each queued frame as one result per pixel into an output register.
module lcf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lcf_pkg::lcf_frame_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lcf_pkg::lcf_out_t   out_item
);

  logic                        active_r,    active_nxt;
  logic [lcf_pkg::PIX_W-1:0]   pix_r,       pix_nxt;
  logic [23:0]                 color_r,     color_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lcf_pkg::lcf_out_t           out_item_r,  out_item_nxt;
  logic                        load;
  logic                        pix_last;

  assign pop      = !active_r && head.valid;
  assign load     = active_r && (!out_valid_r || out_ready);
  assign pix_last = pix_r == lcf_pkg::PIX_LAST;

  // Take a frame, then step through the pixels as the output register frees up
  always_comb begin
    active_nxt    = active_r;
    pix_nxt       = pix_r;
    color_nxt     = color_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      active_nxt = 1'b1;
      pix_nxt    = '0;
      color_nxt  = head.color;
    end
    if (load) begin
      out_item_nxt.pixel_index = 4'(pix_r);
      out_item_nxt.red         = color_r[23:16];
      out_item_nxt.green       = color_r[15:8];
      out_item_nxt.blue        = color_r[7:0];
      out_item_nxt.last_pixel  = pix_last;
      out_valid_nxt            = 1'b1;
      pix_nxt                  = pix_r + 1'b1;
      if (pix_last) begin
        active_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold pixel payload
  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    color_r    <= color_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
